>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/oipd_pkg.sv
// ---------------------------------------------------------------------------
// oipd_pkg
// types, tables and decode helpers of the inner packet deframer
// ---------------------------------------------------------------------------
`default_nettype none

package oipd_pkg;

	// result status codes
	localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
	localparam logic [1:0] STATUS_LAST    = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [1:0] STATUS_TRUNC   = 2'd3;

	localparam int unsigned XTAB_LEN = 13;

	// 3-bit permutation used by both header decodes
	localparam logic [2:0] PERM [8] = '{3'd3, 3'd4, 3'd1, 3'd5, 3'd7, 3'd6, 3'd0, 3'd2};

	// obfuscation table
	localparam logic [7:0] XTAB [XTAB_LEN] = '{
		8'h3f, 8'h26, 8'h42, 8'hfd, 8'h8a, 8'h72, 8'h34,
		8'h74, 8'hc8, 8'hbf, 8'hcd, 8'ha4, 8'h94
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] decoded_byte;
		logic [5:0] opcode;
		logic [7:0] payload_length;
		logic [7:0] byte_index;
		logic       check_passed;
	} out_word_t;

	// value mod 13 for values below 264, by conditional subtraction
	function automatic logic [3:0] mod13(input logic [8:0] v);
		logic [8:0] r;
		r = v;
		if (r >= 9'd208) r = r - 9'd208;
		if (r >= 9'd104) r = r - 9'd104;
		if (r >= 9'd52)  r = r - 9'd52;
		if (r >= 9'd26)  r = r - 9'd26;
		if (r >= 9'd13)  r = r - 9'd13;
		return r[3:0];
	endfunction

	// table entry at a 4-bit position, taken mod 13
	function automatic logic [7:0] xtab_at(input logic [3:0] pos);
		logic [3:0] p;
		p = (pos >= 4'd13) ? (pos - 4'd13) : pos;
		return XTAB[p];
	endfunction

	// payload length from header byte zero
	function automatic logic [7:0] length_of(input logic [7:0] v);
		return {PERM[v[4:2]], v[1:0], PERM[v[7:5]]};
	endfunction

	// opcode from header byte one, once unmasked
	function automatic logic [5:0] opcode_of(input logic [7:0] v);
		logic [2:0] hi;
		hi = PERM[v[4:2]];
		return {hi[0], v[1:0], PERM[v[7:5]]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/obfuscated_inner_packet_deframer.sv
// ---------------------------------------------------------------------------
// obfuscated_inner_packet_deframer
// splits an obfuscated inner byte stream into packets and decodes them
// ---------------------------------------------------------------------------
//  channel | signals                        | word
//  --------+--------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data    | one encoded byte + end mark
//  output  | out_valid, out_ready, out_data | status, byte, header, verdict
//
//  one byte per cycle while in_ready is high; each byte is decoded in the
//  cycle it is accepted and its result, if any, lands in the output
//  register on that edge and is shown on out_data from the cycle after.
//  in_ready stays high while the output register is empty or being drained.
//  after reset the block waits for header byte zero; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module obfuscated_inner_packet_deframer (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  logic                in_valid,
	output logic                      in_ready,
	input  wire  oipd_pkg::in_word_t  in_data,
	output logic                      out_valid,
	input  wire  logic                out_ready,
	output oipd_pkg::out_word_t       out_data
);

	typedef enum logic [1:0] {
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_PAYLOAD
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] length_q, length_d;
	logic [5:0] opcode_q, opcode_d;
	logic [7:0] base_q, base_d;
	logic [7:0] received_q, received_d;
	logic [3:0] xor_pos_q, xor_pos_d;
	logic [7:0] running_q, running_d;
	logic [7:0] count_q, count_d;

	logic                out_valid_q;
	oipd_pkg::out_word_t out_q;

	logic                accept;
	logic                res_valid;
	oipd_pkg::out_word_t res;
	logic                done;

	logic [7:0] b;
	logic       eos;
	logic [7:0] mask;
	logic [7:0] pay_dec;
	logic [7:0] pay_running;
	logic [3:0] pay_pos;
	logic       pay_last;

	assign b   = in_data.data_byte;
	assign eos = in_data.end_of_stream;

	// output register parts the two sides
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// table entry picked by the decoded length
	assign mask = oipd_pkg::xtab_at(oipd_pkg::mod13({1'b0, length_q}));

	oipd_payload u_payload (
		.data_byte     (b),
		.xor_pos       (xor_pos_q),
		.running_check (running_q),
		.odd_index     (count_q[0]),
		.decoded_byte  (pay_dec),
		.running_next  (pay_running),
		.xor_pos_next  (pay_pos)
	);

	assign pay_last = ({1'b0, count_q} + 9'd1) >= {1'b0, length_q};

	// next state and result of one accepted word
	always_comb begin
		phase_d    = phase_q;
		length_d   = length_q;
		opcode_d   = opcode_q;
		base_d     = base_q;
		received_d = received_q;
		xor_pos_d  = xor_pos_q;
		running_d  = running_q;
		count_d    = count_q;
		res_valid  = 1'b0;
		done       = 1'b0;
		res        = '0;

		unique case (phase_q)
			PH_HDR0: begin
				length_d  = oipd_pkg::length_of(b);
				running_d = 8'd0;
				count_d   = 8'd0;
				phase_d   = PH_HDR1;
			end
			PH_HDR1: begin
				opcode_d  = oipd_pkg::opcode_of(mask ^ b);
				base_d    = mask ^ b;
				xor_pos_d = oipd_pkg::mod13({1'b0, b} + 9'd7);
				phase_d   = PH_HDR2;
			end
			PH_HDR2: begin
				received_d = b;
				if (length_q == 8'd0) begin
					res_valid          = 1'b1;
					done               = 1'b1;
					res.status         = oipd_pkg::STATUS_EMPTY;
					res.check_passed   = (b ^ running_q ^ base_q) == length_q;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				running_d = pay_running;
				xor_pos_d = pay_pos;
				count_d   = count_q + 8'd1;
				if (pay_last) begin
					res_valid        = 1'b1;
					done             = 1'b1;
					res.status       = oipd_pkg::STATUS_LAST;
					res.decoded_byte = pay_dec;
					res.byte_index   = count_q;
					res.check_passed = (received_q ^ pay_running ^ base_q) == length_q;
				end else if (!eos) begin
					res_valid        = 1'b1;
					res.status       = oipd_pkg::STATUS_PAYLOAD;
					res.decoded_byte = pay_dec;
					res.byte_index   = count_q;
				end
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase

		// stream ended inside a packet
		if (!done && eos) begin
			res_valid        = 1'b1;
			res.status       = oipd_pkg::STATUS_TRUNC;
			res.decoded_byte = 8'd0;
			res.byte_index   = count_d;
			res.check_passed = 1'b0;
		end
		if (done || eos) begin
			phase_d = PH_HDR0;
		end

		// header fields as they stand after this word
		res.opcode         = opcode_d;
		res.payload_length = length_d;
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			length_q    <= 8'd0;
			opcode_q    <= 6'd0;
			base_q      <= 8'd0;
			received_q  <= 8'd0;
			xor_pos_q   <= 4'd0;
			running_q   <= 8'd0;
			count_q     <= 8'd0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				length_q   <= length_d;
				opcode_q   <= opcode_d;
				base_q     <= base_d;
				received_q <= received_d;
				xor_pos_q  <= xor_pos_d;
				running_q  <= running_d;
				count_q    <= count_d;
			end
			if (accept && res_valid) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks on the packet sequencer
	`ASSERT_IMPLIES(a_payload_nonempty, clk, arst_n, phase_q == PH_PAYLOAD, length_q != 8'd0)
	`ASSERT_IMPLIES(a_count_in_range, clk, arst_n, phase_q == PH_PAYLOAD, count_q < length_q)
	`ASSERT_NEXT(a_eos_restarts, clk, arst_n, accept && eos, phase_q == PH_HDR0)
	`ASSERT_IMPLIES(a_no_verdict_mid, clk, arst_n, out_valid_q && (out_q.status == oipd_pkg::STATUS_PAYLOAD), !out_q.check_passed)
	`ASSERT_IMPLIES(a_zero_byte_end, clk, arst_n, out_valid_q && (out_q.status == oipd_pkg::STATUS_EMPTY || out_q.status == oipd_pkg::STATUS_TRUNC), out_q.decoded_byte == 8'd0)

endmodule

`default_nettype wire

>>> rtl/oipd_payload.sv
// ---------------------------------------------------------------------------
// oipd_payload
// payload byte unmask, rotating table position and alternating-sign check
// ---------------------------------------------------------------------------
`default_nettype none

module oipd_payload (
	input  wire  logic [7:0] data_byte,
	input  wire  logic [3:0] xor_pos,
	input  wire  logic [7:0] running_check,
	input  wire  logic       odd_index,
	output logic       [7:0] decoded_byte,
	output logic       [7:0] running_next,
	output logic       [3:0] xor_pos_next
);

	// unmask with the table entry at the current position
	assign decoded_byte = oipd_pkg::xtab_at(xor_pos) ^ data_byte;

	// minus at even positions, plus at odd positions, mod 256
	assign running_next = odd_index ? (running_check + decoded_byte)
	                                : (running_check - decoded_byte);

	// advance the position, wrapping at the table length
	always_comb begin
		if (xor_pos >= 4'd13) begin
			xor_pos_next = xor_pos - 4'd12;
		end else if (xor_pos == 4'd12) begin
			xor_pos_next = 4'd0;
		end else begin
			xor_pos_next = xor_pos + 4'd1;
		end
	end

endmodule

`default_nettype wire
